### rtl/cpa_pkg.sv
// shared constants, types and codes of the contiguous page allocator
package cpa_pkg;

   localparam int PAGES     = 1024;
   localparam int PAGE_W    = $clog2(PAGES);
   localparam int WORD_BITS = 8;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int WORDS     = PAGES / WORD_BITS;
   localparam int WADDR_W   = $clog2(WORDS);
   localparam int FRAME_W   = 20;
   localparam int CNT_W     = 11;
   localparam int PIU_W     = 11;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FRAME = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGES_USED = 1'b1;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOROOM   = 2'd1;
   localparam logic [1:0] ST_NOTSTART = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_FREE_RD, S_FREE_CHK, S_MARK_RD, S_MARK_WR
   } state_type;

   typedef struct packed {
      logic       clr;
      logic       load;
      logic       scan;
      logic       free_rd;
      logic       free_go;
      logic       mark_rd;
      logic       mark_wr;
      logic       resp;
      logic [1:0] resp_status;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic alloc_bad;
      logic scan_hit;
      logic scan_fail;
      logic free_bad;
      logic mark_last;
   } stat_type;

endpackage

### rtl/cpa_ctrl.sv
// controller state machine of the page allocator
module cpa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_func,
   input  cpa_pkg::stat_type stat,
   output cpa_pkg::cmd_type  cmd,
   output logic              busy
);
   import cpa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               if (req_func == FUNC_FREE) state_in = S_FREE_RD;
               else if (!stat.alloc_bad) state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_hit) state_in = S_MARK_RD;
            else if (stat.scan_fail) state_in = S_IDLE;
         end
         S_FREE_RD: state_in = S_FREE_CHK;
         S_FREE_CHK: begin
            state_in = stat.free_bad ? S_IDLE : S_MARK_RD;
         end
         S_MARK_RD: state_in = S_MARK_WR;
         S_MARK_WR: begin
            state_in = stat.mark_last ? S_IDLE : S_MARK_RD;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_CLEAR: cmd.clr = 1'b1;
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_func == FUNC_ALLOC && stat.alloc_bad) begin
                  cmd.resp        = 1'b1;
                  cmd.resp_status = ST_NOROOM;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (!stat.scan_hit && stat.scan_fail) begin
               cmd.resp        = 1'b1;
               cmd.resp_status = ST_NOROOM;
            end
         end
         S_FREE_RD: cmd.free_rd = 1'b1;
         S_FREE_CHK: begin
            if (stat.free_bad) begin
               cmd.resp        = 1'b1;
               cmd.resp_status = ST_NOTSTART;
            end else begin
               cmd.free_go = 1'b1;
            end
         end
         S_MARK_RD: cmd.mark_rd = 1'b1;
         S_MARK_WR: begin
            cmd.mark_wr = 1'b1;
            if (stat.mark_last) begin
               cmd.resp        = 1'b1;
               cmd.resp_status = ST_OK;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

### rtl/cpa_dp.sv
// datapath of the page allocator: bitmaps, run lengths, scan and marking
module cpa_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [cpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cpa_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                          req_func,
   input  logic [cpa_pkg::CNT_W-1:0]     req_page_count,
   input  logic [cpa_pkg::FRAME_W-1:0]   req_free_frame,
   input  cpa_pkg::cmd_type              cmd,
   output cpa_pkg::stat_type             stat,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [cpa_pkg::FRAME_W-1:0]   rsp_frame
);
   import cpa_pkg::*;

   logic [WORD_BITS-1:0] used_mem  [WORDS];
   logic [WORD_BITS-1:0] start_mem [WORDS];
   logic [CNT_W-1:0]     len_mem   [PAGES];

   logic [FRAME_W-1:0] base_ff;
   logic [PIU_W-1:0]   piu_ff;
   logic               op_free_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [PAGE_W-1:0]  idx_ff;
   logic               oob_ff;
   logic [PAGE_W-1:0]  lo_ff, hi_ff;
   logic [WADDR_W-1:0] wa_ff;
   logic [WADDR_W:0]   sa_ff;
   logic               pv_ff;
   logic [WADDR_W-1:0] pa_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [WADDR_W-1:0] clr_ff;
   logic [WORD_BITS-1:0] used_q, start_q;
   logic [CNT_W-1:0]   len_q;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;

   logic [PIU_W-1:0]     limit;
   logic [FRAME_W-1:0]   diff;
   logic [WADDR_W-1:0]   rd_addr;
   logic                 hit;
   logic [PAGE_W-1:0]    hit_end;
   logic [CNT_W-1:0]     cnt_next;
   logic [PAGE_W-1:0]    hit_start;
   logic [PIU_W-1:0]     last_page;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] used_wr, start_wr;
   logic [CNT_W-1:0]     run_end;

   assign limit     = (piu_ff > PIU_W'(PAGES)) ? PIU_W'(PAGES) : piu_ff;
   assign diff      = req_free_frame - base_ff;
   assign last_page = limit - PIU_W'(1);
   assign rd_addr   = cmd.scan ? sa_ff[WADDR_W-1:0]
                    : cmd.free_rd ? idx_ff[PAGE_W-1:BIT_W] : wa_ff;

   // first-fit over one bitmap word, pages past the limit count as used
   always_comb begin
      logic [CNT_W-1:0]  c;
      logic [PAGE_W-1:0] p;
      logic              u;
      c       = cnt_ff;
      hit     = 1'b0;
      hit_end = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         p = {pa_ff, BIT_W'(j)};
         u = used_q[j] | (PIU_W'(p) >= limit);
         if (!hit) begin
            c = u ? '0 : c + CNT_W'(1);
            if (c == n_ff) begin
               hit     = 1'b1;
               hit_end = p;
            end
         end
      end
      cnt_next = c;
   end

   assign hit_start = PAGE_W'(CNT_W'(hit_end) + CNT_W'(1) - n_ff);

   always_comb begin
      logic [PAGE_W-1:0] p;
      for (int j = 0; j < WORD_BITS; j++) begin
         p       = {wa_ff, BIT_W'(j)};
         mask[j] = (p >= lo_ff) && (p <= hi_ff);
      end
   end

   always_comb begin
      used_wr  = op_free_ff ? (used_q & ~mask) : (used_q | mask);
      start_wr = start_q;
      if (wa_ff == lo_ff[PAGE_W-1:BIT_W]) begin
         start_wr[lo_ff[BIT_W-1:0]] = !op_free_ff;
      end
   end

   assign run_end = CNT_W'(idx_ff) + len_q - CNT_W'(1);

   assign stat.clr_last  = (clr_ff == WADDR_W'(WORDS - 1));
   assign stat.alloc_bad = (req_page_count == '0) || (req_page_count > limit);
   assign stat.scan_hit  = pv_ff && hit;
   assign stat.scan_fail = pv_ff && !hit && (pa_ff == last_page[PAGE_W-1:BIT_W]);
   assign stat.free_bad  = oob_ff || !start_q[idx_ff[BIT_W-1:0]];
   assign stat.mark_last = (wa_ff == hi_ff[PAGE_W-1:BIT_W]);

   // memories: registered read, one write port each
   always_ff @(posedge clock) begin
      used_q  <= used_mem[rd_addr];
      start_q <= start_mem[rd_addr];
      len_q   <= len_mem[idx_ff];
      if (cmd.clr) begin
         used_mem[clr_ff]  <= (clr_ff == '0) ? WORD_BITS'(1) : '0;
         start_mem[clr_ff] <= '0;
      end else if (cmd.mark_wr) begin
         used_mem[wa_ff]  <= used_wr;
         start_mem[wa_ff] <= start_wr;
      end
      if (cmd.scan && stat.scan_hit) begin
         len_mem[hit_start] <= n_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         piu_ff       <= PIU_W'(PAGES);
         clr_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_BASE_FRAME: base_ff <= csr_wdata[FRAME_W-1:0];
               CSR_PAGES_USED: piu_ff  <= csr_wdata[PIU_W-1:0];
               default: ;
            endcase
         end
         if (cmd.clr) clr_ff <= clr_ff + WADDR_W'(1);
         if (cmd.load) pv_ff <= 1'b0;
         else if (cmd.scan) pv_ff <= !sa_ff[WADDR_W];
         rsp_valid_ff <= cmd.resp;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_free_ff <= req_func;
         n_ff       <= req_page_count;
         idx_ff     <= diff[PAGE_W-1:0];
         oob_ff     <= (diff[FRAME_W-1:PAGE_W] != '0);
         sa_ff      <= '0;
         cnt_ff     <= '0;
      end
      if (cmd.scan) begin
         sa_ff  <= sa_ff + (WADDR_W+1)'(1);
         pa_ff  <= sa_ff[WADDR_W-1:0];
         if (pv_ff) cnt_ff <= cnt_next;
         if (stat.scan_hit) begin
            lo_ff <= hit_start;
            hi_ff <= hit_end;
            wa_ff <= hit_start[PAGE_W-1:BIT_W];
         end
      end
      if (cmd.free_go) begin
         lo_ff <= idx_ff;
         hi_ff <= run_end[PAGE_W] ? PAGE_W'(PAGES - 1) : run_end[PAGE_W-1:0];
         wa_ff <= idx_ff[PAGE_W-1:BIT_W];
      end
      if (cmd.mark_wr) wa_ff <= wa_ff + WADDR_W'(1);
      if (cmd.resp) begin
         rsp_status_ff <= cmd.resp_status;
         rsp_frame_ff  <= (cmd.resp_status == ST_OK && !op_free_ff)
                          ? base_ff + FRAME_W'(lo_ff) : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_frame  = rsp_frame_ff;

endmodule

### rtl/contiguous_page_allocator_unit.sv
// top level of the contiguous page allocator
// after reset a clearing pass over all 128 bitmap words runs with busy high; page 0 comes out used
// the scan reads one 8-page word per cycle; a failed one ends at the word of the last page under the limit
// one item at a time; rsp_valid pulses for one cycle and cannot be stalled
module contiguous_page_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [cpa_pkg::CNT_W-1:0]     req_page_count,
   input  logic [cpa_pkg::FRAME_W-1:0]   req_free_frame,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [cpa_pkg::FRAME_W-1:0]   rsp_frame,
   input  logic                          csr_we,
   input  logic [cpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cpa_pkg::CSR_W-1:0]     csr_wdata
);
   import cpa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cpa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   cpa_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_func       (req_func),
      .req_page_count (req_page_count),
      .req_free_frame (req_free_frame),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_frame      (rsp_frame)
   );

endmodule

### rtl/cpa_checker.sv
// port-level checks of the page allocator, bound to the top level
module cpa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [1:0]                    rsp_status,
   input logic [cpa_pkg::FRAME_W-1:0]   rsp_frame
);
   import cpa_pkg::*;

   a_failed_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_frame == '0)
      else $error("refused item carries a frame");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_NOROOM
                    || rsp_status == ST_NOTSTART)
      else $error("unknown status code");

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("not busy clearing after reset");

   a_rsp_needs_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("result with no item in progress");

endmodule

bind contiguous_page_allocator_unit cpa_checker u_cpa_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status),
   .rsp_frame  (rsp_frame)
);

### tb/sv/tb_contiguous_page_allocator_unit.sv
// testbench of the contiguous page allocator: random and directed items checked against a predictor
`timescale 1ns / 1ps
module tb_contiguous_page_allocator_unit;
   import cpa_pkg::*;

   typedef struct {
      logic              func;
      logic [CNT_W-1:0]  count;
      logic [FRAME_W-1:0] frame;
   } page_item_type;

   typedef struct {
      logic [1:0]         status;
      logic [FRAME_W-1:0] frame;
   } page_resp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_func = FUNC_ALLOC;
   logic [CNT_W-1:0]     req_page_count = '0;
   logic [FRAME_W-1:0]   req_free_frame = '0;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic [FRAME_W-1:0]   rsp_frame;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BASE_FRAME;
   logic [CSR_W-1:0]     csr_wdata = '0;

   contiguous_page_allocator_unit uut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [FRAME_W-1:0] model_base;
   logic [PIU_W-1:0]   model_piu;
   logic               page_used [PAGES];
   logic               page_head [PAGES];
   int                 head_len  [PAGES];
   int                 live_heads [$];

   page_item_type pending_items [$];
   page_resp_type expected_resps [$];
   page_item_type cur;
   bit  hold_sender = 0;
   int  burst_left = 4, gap_left = 0;
   int  mismatches = 0, stall_cycles = 0;

   task automatic predict_page_op(input logic func, input logic [CNT_W-1:0] n,
                                  input logic [FRAME_W-1:0] ff);
      page_resp_type r;
      int lim, run, i, s, idx;
      r.status = ST_NOROOM;
      r.frame  = '0;
      lim = (model_piu > PAGES) ? PAGES : model_piu;
      if (func == FUNC_ALLOC) begin
         run = 0;
         if (n != 0 && n <= lim) begin
            for (i = 0; i < lim; i++) begin
               if (page_used[i]) run = 0;
               else begin
                  run++;
                  if (run == n) break;
               end
            end
            if (run == n) begin
               s = i + 1 - n;
               for (i = s; i < s + n; i++) page_used[i] = 1'b1;
               page_head[s] = 1'b1;
               head_len[s]  = n;
               live_heads.push_back(s);
               r.status = ST_OK;
               r.frame  = model_base + FRAME_W'(s);
            end
         end
      end else begin
         idx = int'(FRAME_W'(ff - model_base));
         if (idx >= PAGES || !page_head[idx]) r.status = ST_NOTSTART;
         else begin
            for (i = idx; i < idx + head_len[idx] && i < PAGES; i++) page_used[i] = 1'b0;
            page_head[idx] = 1'b0;
            foreach (live_heads[k]) if (live_heads[k] == idx) begin
               live_heads.delete(k);
               break;
            end
            r.status = ST_OK;
         end
      end
      expected_resps.push_back(r);
   endtask

   // driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) start <= 1'b0;
      else begin
         if (start && !busy) predict_page_op(req_func, req_page_count, req_free_frame);
         if (start && busy) begin
            // item still waiting to be taken
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (!hold_sender && pending_items.size() > 0) begin
            cur = pending_items.pop_front();
            req_func       <= cur.func;
            req_page_count <= cur.count;
            req_free_frame <= cur.frame;
            start          <= 1'b1;
            if (--burst_left <= 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else start <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      page_resp_type e;
      if (!reset && rsp_valid) begin
         if (expected_resps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response status=%0d frame=%h", rsp_status, rsp_frame);
         end else begin
            e = expected_resps.pop_front();
            if (rsp_status !== e.status || rsp_frame !== e.frame) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status=%0d frame=%h, got status=%0d frame=%h",
                           e.status, e.frame, rsp_status, rsp_frame);
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || csr_we) stall_cycles <= 0;
      else if (stall_cycles >= 6000) begin
         $display("TEST FAILED");
         $finish;
      end else stall_cycles <= stall_cycles + 1;
   end

   task automatic push_item(input logic func, input int n, input logic [FRAME_W-1:0] ff);
      page_item_type it;
      while (pending_items.size() >= 2) @(posedge clock);
      it.func  = func;
      it.count = CNT_W'(n);
      it.frame = ff;
      pending_items.push_back(it);
   endtask

   // let the queue empty first, then hold the sender until every result is back
   task automatic drain;
      while (pending_items.size() > 0) @(posedge clock);
      hold_sender = 1;
      while (start || busy || expected_resps.size() > 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
      hold_sender = 0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      drain();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      if (idx == CSR_BASE_FRAME) model_base = FRAME_W'(value);
      else model_piu = PIU_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_items(input int total, input int free_pct);
      int r, n;
      logic [FRAME_W-1:0] ff;
      repeat (total) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 99) >= free_pct) begin
            if (r < 70) n = $urandom_range(1, 8);
            else if (r < 90) n = $urandom_range(9, 64);
            else if (r < 97) n = $urandom_range(65, 1024);
            else n = $urandom_range(0, 2047);
            push_item(FUNC_ALLOC, n, FRAME_W'($urandom));
         end else begin
            if (r < 75 && live_heads.size() > 0)
               ff = model_base + FRAME_W'(live_heads[$urandom_range(0, live_heads.size() - 1)]);
            else if (r < 88) ff = model_base + FRAME_W'($urandom_range(0, 1100));
            else ff = FRAME_W'($urandom);
            push_item(FUNC_FREE, $urandom_range(0, 2047), ff);
         end
      end
   endtask

   initial begin
      model_base = '0;
      model_piu  = PIU_W'(1024);
      foreach (page_used[i]) begin
         page_used[i] = (i == 0);
         page_head[i] = 1'b0;
         head_len[i]  = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed: count extremes, page 0, double free, out of range, first fit
      push_item(FUNC_ALLOC, 0, '0);
      push_item(FUNC_ALLOC, 2047, '0);
      push_item(FUNC_ALLOC, 1024, '0);
      push_item(FUNC_ALLOC, 1023, '0);
      push_item(FUNC_ALLOC, 1, '0);
      push_item(FUNC_FREE, 0, 20'd0);
      push_item(FUNC_FREE, 0, 20'd1);
      push_item(FUNC_FREE, 0, 20'd1);
      push_item(FUNC_FREE, 0, 20'd1024);
      push_item(FUNC_FREE, 2047, 20'hFFFFF);
      push_item(FUNC_ALLOC, 1, 20'hFFFFF);
      push_item(FUNC_ALLOC, 3, '0);
      push_item(FUNC_ALLOC, 1, '0);
      push_item(FUNC_FREE, 0, 20'd1);
      push_item(FUNC_ALLOC, 2, '0);
      push_item(FUNC_ALLOC, 1, '0);
      push_item(FUNC_FREE, 0, 20'd2);
      push_item(FUNC_FREE, 0, 20'd5);
      push_item(FUNC_ALLOC, 4, '0);
      push_item(FUNC_ALLOC, 1018, '0);
      push_item(FUNC_ALLOC, 1017, '0);

      // base at the top so frames wrap
      write_csr(CSR_BASE_FRAME, 20'hFFFFF);
      random_items(70, 40);
      drain();
      random_items(70, 40);
      write_csr(CSR_BASE_FRAME, $urandom_range(0, 20'hFFFFF));
      write_csr(CSR_PAGES_USED, 1);
      random_items(20, 30);
      write_csr(CSR_PAGES_USED, 0);
      random_items(15, 30);
      write_csr(CSR_PAGES_USED, 2047);
      random_items(150, 40);
      // shrink and free what is already held
      write_csr(CSR_PAGES_USED, 40);
      random_items(70, 80);
      write_csr(CSR_BASE_FRAME, $urandom_range(0, 20'hFFFFF));
      write_csr(CSR_PAGES_USED, $urandom_range(16, 200));
      random_items(75, 45);
      drain();
      random_items(75, 45);
      write_csr(CSR_BASE_FRAME, 20'h5A5A5);
      write_csr(CSR_PAGES_USED, 1024);
      random_items(200, 45);

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_resps.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
